### sv/bdd_pkg.sv
// Shared types and constants of the block domain decomposer.
// Field widths, register indexes and the sequencer state encoding.
// No dependencies.
package bdd_pkg;

  localparam int GRID_W = 32;
  localparam int CNT_W  = 11;
  localparam int IDX_W  = 10;
  localparam int ROOT_W = 6;
  localparam int MASK_W = 4;
  localparam int REG_W  = 2;

  localparam logic [REG_W-1:0] REG_GLOBAL_WIDTH  = 2'd0;
  localparam logic [REG_W-1:0] REG_GLOBAL_HEIGHT = 2'd1;
  localparam logic [REG_W-1:0] REG_WORKER_COUNT  = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_LIMIT = 11'd2047;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SQRT  = 7'b0000010,
    S_SRCH  = 7'b0000100,
    S_SWAIT = 7'b0001000,
    S_IDX   = 7'b0010000,
    S_IWAIT = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

endpackage

### sv/bdd_sdiv.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Quotient and remainder hold after done until the next start.
// No dependencies.
module bdd_sdiv #(
  parameter int NW = 32,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] acc;
  logic [DW-1:0] part;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   shifted;
  logic [DW+1:0] diff;
  logic          ge;

  assign shifted = {part, acc[NW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};
  assign ge      = ~diff[DW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= num;
      part  <= '0;
      den_r <= den;
      cnt   <= CW'(NW);
    end else if (busy) begin
      acc  <= {acc[NW-2:0], ge};
      part <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      cnt  <= cnt - CW'(1);
    end
  end

  assign quo = acc;
  assign rem = part;

endmodule

### sv/block_domain_decomposer.sv
// Splits a global grid among worker_count workers (zero counts as one, counts above
// MAX_WORKERS saturate) and describes one worker's tile per request: tile grid shape,
// tile position, tile size and the four neighbor indices with a presence mask.
// Each request runs the 32-bit bit-serial dividers that split the grid width and
// height. The first request after a write of worker_count also derives the tile
// grid first: a bit-serial square root, then a trial of each divisor candidate on
// the 11-bit serial divider (at most 32 candidates with MAX_WORKERS at 1024).
// A finished result waits in the output register while the next request is taken.
// Depends on bdd_pkg and bdd_sdiv.
module block_domain_decomposer #(
  parameter int MAX_WORKERS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bdd_pkg::REG_W-1:0]   cfg_index,
  input  logic [bdd_pkg::GRID_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bdd_pkg::IDX_W-1:0]   worker_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bdd_pkg::CNT_W-1:0]   tiles_across,
  output logic [bdd_pkg::CNT_W-1:0]   tiles_down,
  output logic [bdd_pkg::IDX_W-1:0]   tile_col,
  output logic [bdd_pkg::IDX_W-1:0]   tile_row,
  output logic [bdd_pkg::GRID_W-1:0]  local_width,
  output logic [bdd_pkg::GRID_W-1:0]  local_height,
  output logic [bdd_pkg::IDX_W-1:0]   up_index,
  output logic [bdd_pkg::IDX_W-1:0]   right_index,
  output logic [bdd_pkg::IDX_W-1:0]   down_index,
  output logic [bdd_pkg::IDX_W-1:0]   left_index,
  output logic [bdd_pkg::MASK_W-1:0]  neighbor_present
);
  import bdd_pkg::*;

  localparam int CLAMP_INT = (MAX_WORKERS > 2047) ? 2047 : MAX_WORKERS;
  localparam logic [CNT_W-1:0] P_MAX = CLAMP_INT[CNT_W-1:0];

  state_t state;

  logic [GRID_W-1:0] gw;
  logic [GRID_W-1:0] gh;
  logic [CNT_W-1:0]  wc;
  logic [CNT_W-1:0]  p;

  logic [CNT_W-1:0]  cols;
  logic [CNT_W-1:0]  rows;
  logic              dirty;
  logic [IDX_W-1:0]  idx;

  logic [ROOT_W-1:0] root;
  logic [ROOT_W-1:0] root_bit;
  logic [ROOT_W-1:0] trial;
  logic [2*ROOT_W-1:0] trial_sq;
  logic [ROOT_W-1:0] cand;

  logic              s_start;
  logic [CNT_W-1:0]  s_num;
  logic [CNT_W-1:0]  s_den;
  logic              s_done;
  logic [CNT_W-1:0]  s_quo;
  logic [CNT_W-1:0]  s_rem;

  logic              g_start;
  logic              w_done;
  logic              h_done;
  logic [GRID_W-1:0] w_quo;
  logic [CNT_W-1:0]  w_rem;
  logic [GRID_W-1:0] h_quo;
  logic [CNT_W-1:0]  h_rem;

  logic [IDX_W-1:0]  col;
  logic [IDX_W-1:0]  row;
  logic              load;
  logic [MASK_W-1:0] mask;

  assign p = (wc == '0) ? CNT_W'(1) : ((wc > P_MAX) ? P_MAX : wc);

  assign trial    = root | root_bit;
  assign trial_sq = trial * trial;

  assign in_ready = (state == S_IDLE);
  assign load     = (state == S_DONE) && (!out_valid || out_ready);

  assign s_start = (state == S_SRCH) || (state == S_IDX);
  assign s_num   = (state == S_SRCH) ? p : {1'b0, idx};
  assign s_den   = (state == S_SRCH) ? {{(CNT_W-ROOT_W){1'b0}}, cand} : cols;
  assign g_start = (state == S_IDX);

  assign col = s_rem[IDX_W-1:0];
  assign row = s_quo[IDX_W-1:0];

  assign mask[0] = (row != '0);
  assign mask[1] = ({1'b0, col} + CNT_W'(1)) < cols;
  assign mask[2] = ({1'b0, row} + CNT_W'(1)) < rows;
  assign mask[3] = (col != '0);

  bdd_sdiv #(.NW(CNT_W), .DW(CNT_W)) u_sdiv (
    .clk(clk), .rst(rst), .start(s_start), .num(s_num), .den(s_den),
    .done(s_done), .quo(s_quo), .rem(s_rem)
  );

  bdd_sdiv #(.NW(GRID_W), .DW(CNT_W)) u_wdiv (
    .clk(clk), .rst(rst), .start(g_start), .num(gw), .den(cols),
    .done(w_done), .quo(w_quo), .rem(w_rem)
  );

  bdd_sdiv #(.NW(GRID_W), .DW(CNT_W)) u_hdiv (
    .clk(clk), .rst(rst), .start(g_start), .num(gh), .den(rows),
    .done(h_done), .quo(h_quo), .rem(h_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gw    <= '0;
      gh    <= '0;
      wc    <= CNT_W'(1);
      cols  <= CNT_W'(1);
      rows  <= CNT_W'(1);
      dirty <= 1'b0;
      state <= S_IDLE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GLOBAL_WIDTH:  gw <= cfg_data;
          REG_GLOBAL_HEIGHT: gh <= cfg_data;
          REG_WORKER_COUNT: begin
            wc    <= cfg_data[CNT_W-1:0];
            dirty <= 1'b1;
          end
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= dirty ? S_SQRT : S_IDX;
        end
        S_SQRT: begin
          if (root_bit[0]) state <= S_SRCH;
        end
        S_SRCH: state <= S_SWAIT;
        S_SWAIT: begin
          if (s_done) begin
            if (s_rem == '0) begin
              cols  <= {{(CNT_W-ROOT_W){1'b0}}, cand};
              rows  <= s_quo;
              dirty <= 1'b0;
              state <= S_IDX;
            end else begin
              state <= S_SRCH;
            end
          end
        end
        S_IDX: state <= S_IWAIT;
        S_IWAIT: begin
          if (w_done && h_done) state <= S_DONE;
        end
        S_DONE: begin
          if (load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      idx      <= worker_index;
      root     <= '0;
      root_bit <= {1'b1, {(ROOT_W-1){1'b0}}};
    end
    if (state == S_SQRT) begin
      if ({1'b0, p} >= trial_sq) root <= trial;
      root_bit <= root_bit >> 1;
      if (root_bit[0]) cand <= ({1'b0, p} >= trial_sq) ? trial : root;
    end
    if (state == S_SWAIT && s_done && s_rem != '0) cand <= cand - ROOT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tiles_across     <= cols;
      tiles_down       <= rows;
      tile_col         <= col;
      tile_row         <= row;
      local_width      <= w_quo + GRID_W'({1'b0, col} < w_rem);
      local_height     <= h_quo + GRID_W'({1'b0, row} < h_rem);
      up_index         <= mask[0] ? idx - cols[IDX_W-1:0] : '0;
      right_index      <= mask[1] ? idx + IDX_W'(1) : '0;
      down_index       <= mask[2] ? idx + cols[IDX_W-1:0] : '0;
      left_index       <= mask[3] ? idx - IDX_W'(1) : '0;
      neighbor_present <= mask;
    end
  end

  a_cols_nonzero: assert property (@(posedge clk) disable iff (rst)
    cols != '0 && rows != '0)
    else $error("tile grid shape has a zero dimension");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while a request is in progress");

  a_grid_settled: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> !dirty)
    else $error("result produced with stale tile grid");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, tile_col} < tiles_across))
    else $error("tile column outside tile grid");

endmodule

### sim/block_domain_decomposer_tb.sv
// Testbench for block_domain_decomposer: predicts tile shape, position, size and
// neighbor indices per request and checks every result in order, under random stalls.
// Depends on bdd_pkg and the block_domain_decomposer RTL.
`timescale 1ns / 100ps

module block_domain_decomposer_tb;
  import bdd_pkg::*;

  localparam int MAX_WORKERS   = 1024;
  localparam int RANDOM_ITEMS  = 950;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 64;

  typedef struct packed {
    logic [CNT_W-1:0]  n_across;
    logic [CNT_W-1:0]  n_down;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  row;
    logic [GRID_W-1:0] width;
    logic [GRID_W-1:0] height;
    logic [IDX_W-1:0]  up;
    logic [IDX_W-1:0]  right;
    logic [IDX_W-1:0]  down;
    logic [IDX_W-1:0]  left;
    logic [MASK_W-1:0] mask;
  } tile_info_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [REG_W-1:0]  cfg_index = '0;
  logic [GRID_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [IDX_W-1:0]  worker_index = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CNT_W-1:0]  tiles_across;
  logic [CNT_W-1:0]  tiles_down;
  logic [IDX_W-1:0]  tile_col;
  logic [IDX_W-1:0]  tile_row;
  logic [GRID_W-1:0] local_width;
  logic [GRID_W-1:0] local_height;
  logic [IDX_W-1:0]  up_index;
  logic [IDX_W-1:0]  right_index;
  logic [IDX_W-1:0]  down_index;
  logic [IDX_W-1:0]  left_index;
  logic [MASK_W-1:0] neighbor_present;

  logic [GRID_W-1:0] grid_width_cfg = '0;
  logic [GRID_W-1:0] grid_height_cfg = '0;
  logic [CNT_W-1:0]  worker_count_cfg = 11'd1;

  tile_info_t pending_tiles[$];
  bit         no_idle = 1'b0;
  int         stall_left = 0;
  int         cycle_count = 0;
  int         requests_sent = 0;
  int         results_checked = 0;
  int         settings_applied = 0;
  int         mismatches = 0;

  block_domain_decomposer #(
    .MAX_WORKERS(MAX_WORKERS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .worker_index(worker_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .tiles_across(tiles_across),
    .tiles_down(tiles_down),
    .tile_col(tile_col),
    .tile_row(tile_row),
    .local_width(local_width),
    .local_height(local_height),
    .up_index(up_index),
    .right_index(right_index),
    .down_index(down_index),
    .left_index(left_index),
    .neighbor_present(neighbor_present)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned workers_in_use();
    if (worker_count_cfg == '0) return 1;
    if (worker_count_cfg > MAX_WORKERS) return MAX_WORKERS;
    return worker_count_cfg;
  endfunction

  function automatic logic [GRID_W-1:0] tile_share(input logic [GRID_W-1:0] total,
                                                   input int unsigned parts,
                                                   input int unsigned pos);
    logic [GRID_W-1:0] q;
    logic [GRID_W-1:0] rem;
    q   = total / parts;
    rem = total % parts;
    return (pos < rem) ? q + 1 : q;
  endfunction

  function automatic tile_info_t predict_tile(input logic [IDX_W-1:0] idx);
    int unsigned p;
    int unsigned root;
    int unsigned cols;
    int unsigned rows;
    int unsigned col;
    int unsigned row;
    int unsigned nb;
    tile_info_t  t;
    p    = workers_in_use();
    root = 0;
    while ((root + 1) * (root + 1) <= p) root++;
    cols = (root == 0) ? 1 : root;
    while (p % cols != 0) cols--;
    rows = p / cols;
    col  = idx % cols;
    row  = idx / cols;
    t = '0;
    t.n_across = cols[CNT_W-1:0];
    t.n_down   = rows[CNT_W-1:0];
    t.col      = col[IDX_W-1:0];
    t.row      = row[IDX_W-1:0];
    t.width    = tile_share(grid_width_cfg, cols, col);
    t.height   = tile_share(grid_height_cfg, rows, row);
    if (row > 0) begin
      nb = (row - 1) * cols + col;
      t.up = nb[IDX_W-1:0];
      t.mask[0] = 1'b1;
    end
    if (col + 1 < cols) begin
      nb = row * cols + col + 1;
      t.right = nb[IDX_W-1:0];
      t.mask[1] = 1'b1;
    end
    if (row + 1 < rows) begin
      nb = (row + 1) * cols + col;
      t.down = nb[IDX_W-1:0];
      t.mask[2] = 1'b1;
    end
    if (col > 0) begin
      nb = row * cols + col - 1;
      t.left = nb[IDX_W-1:0];
      t.mask[3] = 1'b1;
    end
    return t;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [GRID_W-1:0] pick_extent();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return $urandom_range(0, 100);
    return $urandom;
  endfunction

  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [GRID_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_GLOBAL_WIDTH: begin
        grid_width_cfg = value;
      end
      REG_GLOBAL_HEIGHT: begin
        grid_height_cfg = value;
      end
      REG_WORKER_COUNT: begin
        worker_count_cfg = value[CNT_W-1:0];
      end
      default: begin
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_grid(input logic [GRID_W-1:0] w, input logic [GRID_W-1:0] h,
                          input logic [GRID_W-1:0] count);
    write_reg(REG_GLOBAL_WIDTH, w);
    write_reg(REG_GLOBAL_HEIGHT, h);
    write_reg(REG_WORKER_COUNT, count);
    settings_applied++;
  endtask

  task automatic send_request(input logic [IDX_W-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    worker_index <= idx;
    pending_tiles.push_back(predict_tile(idx));
    requests_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic check_field(input string field, input logic [GRID_W-1:0] want,
                             input logic [GRID_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    tile_info_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_tiles.size() == 0) begin
        mismatches++;
        $display("%0t: result with no pending request, tile_col %0d tile_row %0d",
                 $time, tile_col, tile_row);
      end else begin
        want = pending_tiles.pop_front();
        results_checked++;
        check_field("tiles_across", want.n_across, tiles_across);
        check_field("tiles_down", want.n_down, tiles_down);
        check_field("tile_col", want.col, tile_col);
        check_field("tile_row", want.row, tile_row);
        check_field("local_width", want.width, local_width);
        check_field("local_height", want.height, local_height);
        check_field("up_index", want.up, up_index);
        check_field("right_index", want.right, right_index);
        check_field("down_index", want.down, down_index);
        check_field("left_index", want.left, left_index);
        check_field("neighbor_present", want.mask, neighbor_present);
      end
    end
  end

  always @(posedge clk) begin : ready_stalls
    int gap_len;
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      gap_len = pick_gap();
      if (gap_len == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left = gap_len - 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    send_request('0);
    send_request('1);
    drain_requests();
  endtask

  task automatic test_worker_count_limits();
    set_grid(32'd13, 32'd9, 32'd0);
    send_request(10'd0);
    send_request(10'd5);
    drain_requests();
    set_grid(32'd100, 32'd77, 32'd2047);
    send_request(10'd0);
    send_request(10'd1023);
    send_request(10'd527);
    drain_requests();
    set_grid(32'd5, 32'd3, 32'd1025);
    send_request(10'd1);
    drain_requests();
    set_grid('1, '1, 32'd1024);
    send_request(10'd0);
    send_request(10'd1023);
    send_request(10'd33);
    drain_requests();
  endtask

  task automatic test_tile_shapes();
    set_grid(32'd1000, 32'd0, 32'd1021);
    send_request(10'd0);
    send_request(10'd1020);
    send_request(10'd1023);
    drain_requests();
    set_grid(32'd7, 32'd10, 32'd12);
    send_request(10'd4);
    send_request(10'd11);
    send_request(10'd12);
    send_request(10'd13);
    drain_requests();
    set_grid(32'd17, 32'd18, 32'd16);
    send_request(10'd5);
    send_request(10'd15);
    drain_requests();
    set_grid(32'd1, 32'd1, 32'd2);
    send_request(10'd1);
    drain_requests();
  endtask

  task automatic test_random_grids();
    int target;
    int n_items;
    int r;
    logic [GRID_W-1:0] count;
    bit first;
    first  = 1'b1;
    target = requests_sent + RANDOM_ITEMS;
    while (requests_sent < target) begin
      r = $urandom_range(0, 9);
      if (r < 6) count = $urandom_range(1, 64);
      else if (r < 8) count = $urandom_range(1, 1024);
      else if (r == 8) count = $urandom;
      else begin
        case ($urandom_range(0, 4))
          0: count = 32'd0;
          1: count = 32'd1;
          2: count = 32'd1024;
          3: count = 32'd2047;
          default: count = $urandom_range(1025, 2047);
        endcase
      end
      if (first || $urandom_range(0, 3) != 0) write_reg(REG_GLOBAL_WIDTH, pick_extent());
      if (first || $urandom_range(0, 3) != 0) write_reg(REG_GLOBAL_HEIGHT, pick_extent());
      if (first || $urandom_range(0, 3) != 0) write_reg(REG_WORKER_COUNT, count);
      settings_applied++;
      first   = 1'b0;
      no_idle = ($urandom_range(0, 5) == 0);
      n_items = $urandom_range(10, 40);
      repeat (n_items) begin
        if ($urandom_range(0, 99) < 85) send_request($urandom_range(0, workers_in_use() - 1));
        else send_request($urandom_range(0, 1023));
        if ($urandom_range(0, 29) == 0) drain_requests();
      end
      drain_requests();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_worker_count_limits();
    test_tile_shapes();
    test_random_grids();
    drain_requests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests across %0d grid settings; %0d results checked, %0d mismatches.",
             requests_sent, settings_applied, results_checked, mismatches);
    if (mismatches == 0 && pending_tiles.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
